>>> rtl/plce_pkg.sv
// shared types and constants for the palette line change encoder
`timescale 1ns / 1ps

package plce_pkg;

  // per-line cap on change entries when all_changes is off
  localparam int CHANGE_CAP = 7;
  // source lines at or above this are dropped
  localparam int MAX_LINES  = 1024;

  // result queue depth
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [3:0]  LAST_REG    = 4'd15;
  localparam logic [4:0]  NO_MIN_REG  = 5'd16;
  localparam logic [4:0]  LINE_CNT_MAX = 5'd31;
  localparam logic [15:0] TOTAL_MAX   = 16'hFFFF;
  localparam logic [9:0]  LINES_MAX   = 10'd1023;

  typedef enum logic [1:0] {
    CFG_ALL_CHANGES = 2'd0,
    CFG_LINE_STEP   = 2'd1,
    CFG_MASK_SCALE  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_CHANGE  = 2'd0,
    KIND_SUMMARY = 2'd1,
    KIND_BASE    = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  out_reg;
    logic [15:0] packed_word;
    logic [23:0] rgb24;
    logic [10:0] mask_line;
    logic [4:0]  line_changes;
    logic [15:0] total_changes;
    logic [4:0]  peak_changes;
    logic [9:0]  lines_changed;
    logic [4:0]  lowest_reg;
    logic [3:0]  highest_reg;
    logic        line_has_change;
  } res_t;

  // each nibble lands in the top of its byte
  function automatic logic [23:0] expand24(input logic [11:0] c);
    expand24 = {c[11:8], 4'h0, c[7:4], 4'h0, c[3:0], 4'h0};
  endfunction

  function automatic res_t make_entry(input kind_t k, input logic [3:0] r,
                                      input logic [11:0] c);
    res_t e;
    e             = '0;
    e.kind        = k;
    e.out_reg     = r;
    e.packed_word = {r, c};
    e.rgb24       = expand24(c);
    make_entry    = e;
  endfunction

endpackage

>>> rtl/palette_line_change_encoder_unit.sv
// palette line change encoder: palette compare, statistics and result queue
`timescale 1ns / 1ps

//  channel  direction  handshake            payload
//  in_      input      in_valid / in_stall   line_index, reg_index, color
//  out_     output     out_valid / out_stall kind .. line_has_change (12 fields)
//  cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  an input item is compared and the statistics updated in the cycle it is
//  taken; its 0, 1 or 2 results go into a 4-entry result queue.
//  one item per cycle while each item gives at most one result and out_stall
//  is low; an item's change entry and line summary leave the queue one at a time.
//  in_stall rises when the queue has fewer than two free slots.
//  rst_n clears config, statistics and the queue; the palette store is not reset.

module palette_line_change_encoder_unit
  import plce_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  in_line_index,
  input  logic [3:0]  in_reg_index,
  input  logic [11:0] in_color,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [3:0]  out_out_reg,
  output logic [15:0] out_packed_word,
  output logic [23:0] out_rgb24,
  output logic [10:0] out_mask_line,
  output logic [4:0]  out_line_changes,
  output logic [15:0] out_total_changes,
  output logic [4:0]  out_peak_changes,
  output logic [9:0]  out_lines_changed,
  output logic [4:0]  out_lowest_reg,
  output logic [3:0]  out_highest_reg,
  output logic        out_line_has_change,

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [1:0]  cfg_data
);

  // configuration
  logic       all_changes_r;
  logic [1:0] line_step_r;
  logic [1:0] mask_scale_r;

  // statistics
  logic [4:0]  line_cnt_r,  line_cnt_nxt;
  logic [15:0] total_r,     total_nxt;
  logic [4:0]  peak_r,      peak_nxt;
  logic [9:0]  lines_r,     lines_nxt;
  logic [4:0]  min_reg_r,   min_reg_nxt;
  logic [3:0]  max_reg_r,   max_reg_nxt;

  // last kept palette, undefined until line 0 writes it
  logic [11:0] ref_pal_r [16];

  // result queue
  res_t              queue_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r,  count_nxt;

  logic       in_accept;
  logic       pop;
  logic       ref_we;
  logic [1:0] n_push;
  res_t       ent0, ent1, head;

  logic        line_ok, kept, base_line, diff, allow;
  logic [11:0] ref_col;
  logic [10:0] mask_line;
  logic        has_change;
  res_t        summary;

  assign cfg_ready = 1'b1;
  assign in_stall  = count_r > QCNT_W'(QDEPTH - 2);
  assign in_accept = in_valid && !in_stall;
  assign out_valid = count_r != '0;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      all_changes_r <= 1'b0;
      line_step_r   <= 2'd1;
      mask_scale_r  <= 2'd1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ALL_CHANGES: all_changes_r <= cfg_data[0];
        CFG_LINE_STEP:   line_step_r   <= cfg_data;
        CFG_MASK_SCALE:  mask_scale_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ref_col   = ref_pal_r[in_reg_index];
  assign line_ok   = 32'(in_line_index) < MAX_LINES;
  assign base_line = in_line_index == '0;
  // step 2 or 3 keeps even lines only
  assign kept      = !line_step_r[1] || !in_line_index[0];
  assign diff      = in_color != ref_col;
  assign allow     = all_changes_r || (32'(line_cnt_r) < CHANGE_CAP);
  assign mask_line = mask_scale_r[1] ? {in_line_index, 1'b0} : {1'b0, in_line_index};

  always_comb begin
    line_cnt_nxt = line_cnt_r;
    total_nxt    = total_r;
    peak_nxt     = peak_r;
    lines_nxt    = lines_r;
    min_reg_nxt  = min_reg_r;
    max_reg_nxt  = max_reg_r;
    ref_we       = 1'b0;
    n_push       = 2'd0;
    ent0         = '0;
    ent1         = '0;
    has_change   = 1'b0;
    summary      = '0;

    if (in_accept && line_ok) begin
      if (base_line) begin
        // register 0 of line 0 starts a new image
        if (in_reg_index == '0) begin
          line_cnt_nxt = '0;
          total_nxt    = '0;
          peak_nxt     = '0;
          lines_nxt    = '0;
          min_reg_nxt  = NO_MIN_REG;
          max_reg_nxt  = '0;
        end
        if (in_reg_index == LAST_REG) line_cnt_nxt = '0;
        ref_we = 1'b1;
        ent0   = make_entry(KIND_BASE, in_reg_index, in_color);
        n_push = 2'd1;
      end else if (kept) begin
        if (diff) begin
          ref_we = 1'b1;
          if (allow) begin
            if (in_reg_index > max_reg_r) max_reg_nxt = in_reg_index;
            if ({1'b0, in_reg_index} < min_reg_r) min_reg_nxt = {1'b0, in_reg_index};
            if (total_r != TOTAL_MAX) total_nxt = total_r + 16'd1;
            if (line_cnt_r != LINE_CNT_MAX) line_cnt_nxt = line_cnt_r + 5'd1;
            ent0   = make_entry(KIND_CHANGE, in_reg_index, in_color);
            n_push = 2'd1;
          end
        end
        if (in_reg_index == LAST_REG) begin
          has_change = line_cnt_nxt != '0;
          if (has_change) begin
            if (lines_r != LINES_MAX) lines_nxt = lines_r + 10'd1;
            if (peak_r < line_cnt_nxt) peak_nxt = line_cnt_nxt;
          end
          summary.kind            = KIND_SUMMARY;
          summary.mask_line       = mask_line;
          summary.line_changes    = line_cnt_nxt;
          summary.total_changes   = total_nxt;
          summary.peak_changes    = peak_nxt;
          summary.lines_changed   = lines_nxt;
          summary.lowest_reg      = min_reg_nxt;
          summary.highest_reg     = max_reg_nxt;
          summary.line_has_change = has_change;
          line_cnt_nxt = '0;
          if (n_push == 2'd1) begin
            ent1   = summary;
            n_push = 2'd2;
          end else begin
            ent0   = summary;
            n_push = 2'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r <= '0;
      total_r    <= '0;
      peak_r     <= '0;
      lines_r    <= '0;
      min_reg_r  <= NO_MIN_REG;
      max_reg_r  <= '0;
    end else begin
      line_cnt_r <= line_cnt_nxt;
      total_r    <= total_nxt;
      peak_r     <= peak_nxt;
      lines_r    <= lines_nxt;
      min_reg_r  <= min_reg_nxt;
      max_reg_r  <= max_reg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ref_we) ref_pal_r[in_reg_index] <= in_color;
  end

  // queue pointers
  assign wr_ptr_nxt = wr_ptr_r + QPTR_W'(n_push);
  assign rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
  assign count_nxt  = count_r + QCNT_W'(n_push) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) queue_r[wr_ptr_r] <= ent0;
    if (n_push == 2'd2) queue_r[wr_ptr_r + QPTR_W'(1)] <= ent1;
  end

  assign head                = queue_r[rd_ptr_r];
  assign out_kind            = head.kind;
  assign out_out_reg         = head.out_reg;
  assign out_packed_word     = head.packed_word;
  assign out_rgb24           = head.rgb24;
  assign out_mask_line       = head.mask_line;
  assign out_line_changes    = head.line_changes;
  assign out_total_changes   = head.total_changes;
  assign out_peak_changes    = head.peak_changes;
  assign out_lines_changed   = head.lines_changed;
  assign out_lowest_reg      = head.lowest_reg;
  assign out_highest_reg     = head.highest_reg;
  assign out_line_has_change = head.line_has_change;

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= QDEPTH)
    else $error("result queue over capacity");

  a_base_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_line_index == '0 |=> out_valid)
    else $error("base line transaction gave no result");

  a_min_reg_range: assert property (@(posedge clk) disable iff (!rst_n)
    min_reg_r <= NO_MIN_REG)
    else $error("lowest register out of range");

  a_summary_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SUMMARY |->
      out_line_has_change == (out_line_changes != '0))
    else $error("summary change flag disagrees with line count");

endmodule
